// File: rtl/core/iee_pkg.sv
`default_nettype none
package iee_pkg;

  // Token classes produced by the front end
  typedef enum logic [2:0] {
    TK_NONE,
    TK_DIGIT,
    TK_MUL,
    TK_DIV,
    TK_ADD,
    TK_SUB
  } tok_kind_t;

  // One queue entry: class, digit value, end-of-expression mark
  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  // Multiplicative operator waiting for its right operand
  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } mul_op_t;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TIMES = 8'h78;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Token queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECODE,
    BK_CHKLAST,
    BK_OPND,
    BK_MDWAIT,
    BK_AFTER,
    BK_TERM,
    BK_EMIT
  } bk_state_t;

  // Multiply/divide unit
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic       done;
    logic [1:0] err;
  } md_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/iee_fifo.sv
`default_nettype none
module iee_fifo (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  iee_pkg::tok_t  push_tok,
  output logic           full,
  input  wire            pop,
  output logic           valid,
  output iee_pkg::tok_t  head_tok
);

  iee_pkg::tok_t                  mem_r [iee_pkg::QDEPTH];
  logic [iee_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [iee_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [iee_pkg::QPTR_W:0]       cnt_r;

  assign full     = (cnt_r == (iee_pkg::QPTR_W + 1)'(iee_pkg::QDEPTH));
  assign valid    = (cnt_r != '0);
  assign head_tok = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push && !full, pop && valid})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/iee_front.sv
`default_nettype none
module iee_front (
  input  wire            in_tvalid,
  output logic           in_tready,
  input  wire [7:0]      in_tdata,   // [7:0] char_code
  input  wire            in_tlast,   // last_char
  input  wire            q_full,
  output logic           q_push,
  output iee_pkg::tok_t  q_tok
);

  // Classify the character
  always_comb begin
    q_tok.kind  = iee_pkg::TK_NONE;
    q_tok.digit = in_tdata[3:0];
    q_tok.last  = in_tlast;
    if (in_tdata >= iee_pkg::CH_ZERO && in_tdata <= iee_pkg::CH_NINE) begin
      q_tok.kind = iee_pkg::TK_DIGIT;
    end else begin
      unique case (in_tdata)
        iee_pkg::CH_TIMES: q_tok.kind = iee_pkg::TK_MUL;
        iee_pkg::CH_SLASH: q_tok.kind = iee_pkg::TK_DIV;
        iee_pkg::CH_PLUS:  q_tok.kind = iee_pkg::TK_ADD;
        iee_pkg::CH_MINUS: q_tok.kind = iee_pkg::TK_SUB;
        default:           q_tok.kind = iee_pkg::TK_NONE;
      endcase
    end
  end

  // Ignored characters are dropped unless they end the expression
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full &&
                     ((q_tok.kind != iee_pkg::TK_NONE) || in_tlast);

endmodule
`default_nettype wire

// File: rtl/core/iee_muldiv.sv
`default_nettype none
module iee_muldiv #(
  parameter int unsigned W = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  iee_pkg::md_req_t       req,
  input  wire signed [W-1:0]     op_a,
  input  wire signed [W-1:0]     op_b,
  output iee_pkg::md_rsp_t       rsp,
  output logic signed [W-1:0]    result
);

  localparam int unsigned CW = $clog2(W);

  iee_pkg::md_state_t state_r, state_nxt;
  logic [W-1:0]  opd_r;    // multiplicand or divisor magnitude
  logic [W-1:0]  sh_r;     // multiplier bits, or dividend bits then quotient
  logic [W:0]    acc_r;    // partial product or remainder
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic          is_div_r;
  logic          ovf_r;
  logic          dz_r;

  logic [W-1:0]  a_mag, b_mag;
  logic [W:0]    lim;
  logic [W:0]    mul_sum;
  logic [W:0]    div_r2;
  logic          div_ge;
  logic [W-1:0]  mag;
  logic          ovf_fin;

  // Operand magnitudes
  assign a_mag = op_a[W-1] ? (W)'(-op_a) : op_a;
  assign b_mag = op_b[W-1] ? (W)'(-op_b) : op_b;

  // Largest product magnitude for the result sign
  assign lim = neg_r ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};

  // One shift-add or one restoring-divide step
  assign mul_sum = {acc_r[W-1:0], 1'b0} + {1'b0, (sh_r[W-1] ? opd_r : {W{1'b0}})};
  assign div_r2  = {acc_r[W-1:0], sh_r[W-1]};
  assign div_ge  = (div_r2 >= {1'b0, opd_r});

  // Final magnitude and overflow
  assign mag     = is_div_r ? sh_r : acc_r[W-1:0];
  assign ovf_fin = is_div_r ? (!neg_r && sh_r[W-1]) : ovf_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iee_pkg::MD_IDLE: begin
        if (req.start) begin
          state_nxt = (req.is_div && (op_b == '0)) ? iee_pkg::MD_DONE : iee_pkg::MD_RUN;
        end
      end
      iee_pkg::MD_RUN: begin
        if (cnt_r == CW'(W - 1)) begin
          state_nxt = iee_pkg::MD_DONE;
        end
      end
      iee_pkg::MD_DONE: state_nxt = iee_pkg::MD_IDLE;
      default:          state_nxt = iee_pkg::MD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.done = 1'b0;
    rsp.err  = iee_pkg::ST_OK;
    result   = '0;
    if (state_r == iee_pkg::MD_DONE) begin
      rsp.done = 1'b1;
      if (dz_r) begin
        rsp.err = iee_pkg::ST_DIV0;
      end else if (ovf_fin) begin
        rsp.err = iee_pkg::ST_OVF;
      end else begin
        result = neg_r ? $signed(-mag) : $signed(mag);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iee_pkg::MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      iee_pkg::MD_IDLE: begin
        if (req.start) begin
          is_div_r <= req.is_div;
          neg_r    <= op_a[W-1] ^ op_b[W-1];
          opd_r    <= req.is_div ? b_mag : a_mag;
          sh_r     <= req.is_div ? a_mag : b_mag;
          acc_r    <= '0;
          cnt_r    <= '0;
          ovf_r    <= 1'b0;
          dz_r     <= req.is_div && (op_b == '0);
        end
      end
      iee_pkg::MD_RUN: begin
        cnt_r <= cnt_r + 1'b1;
        if (is_div_r) begin
          acc_r <= div_ge ? (div_r2 - {1'b0, opd_r}) : div_r2;
          sh_r  <= {sh_r[W-2:0], div_ge};
        end else begin
          acc_r <= mul_sum;
          sh_r  <= {sh_r[W-2:0], 1'b0};
          if (mul_sum > lim) begin
            ovf_r <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/iee_back.sv
`default_nettype none
module iee_back #(
  parameter int unsigned W = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  iee_pkg::tok_t          q_tok,
  output logic                   q_pop,
  output iee_pkg::md_req_t       md_req,
  output logic signed [W-1:0]    md_a,
  output logic signed [W-1:0]    md_b,
  input  iee_pkg::md_rsp_t       md_rsp,
  input  wire signed [W-1:0]     md_result,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [31:0]            out_value,
  output logic [1:0]             out_status
);

  iee_pkg::bk_state_t state_r, state_nxt;
  iee_pkg::tok_t      tok_r;
  iee_pkg::mul_op_t   pend_r;
  logic signed [W-1:0] sum_r;
  logic signed [W-1:0] term_r;
  logic signed [W-1:0] acc_r;
  logic               sub_r;
  logic [1:0]         err_r;
  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic [1:0]         out_status_r;

  logic [W+3:0]       acc10;
  logic               dig_ovf;
  logic [W:0]         ext_s, ext_t, sum_w;
  logic               as_ovf;
  logic               emit_ok;

  // Operand digit: acc*10 + d, checked against the signed maximum
  assign acc10   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (W + 4)'(tok_r.digit);
  assign dig_ovf = acc10 > {5'b0, {(W-1){1'b1}}};

  // Term into running sum
  assign ext_s  = {sum_r[W-1], sum_r};
  assign ext_t  = {term_r[W-1], term_r};
  assign sum_w  = sub_r ? (ext_s - ext_t) : (ext_s + ext_t);
  assign as_ovf = sum_w[W] ^ sum_w[W-1];

  assign emit_ok = !out_valid_r || out_tready;

  assign md_a       = term_r;
  assign md_b       = acc_r;
  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iee_pkg::BK_IDLE: begin
        if (q_valid) state_nxt = iee_pkg::BK_DECODE;
      end
      iee_pkg::BK_DECODE: begin
        if (err_r != iee_pkg::ST_OK || tok_r.kind == iee_pkg::TK_DIGIT ||
            tok_r.kind == iee_pkg::TK_NONE) begin
          state_nxt = iee_pkg::BK_CHKLAST;
        end else begin
          state_nxt = iee_pkg::BK_OPND;
        end
      end
      iee_pkg::BK_CHKLAST: begin
        if (!tok_r.last) begin
          state_nxt = iee_pkg::BK_IDLE;
        end else if (err_r != iee_pkg::ST_OK) begin
          state_nxt = iee_pkg::BK_EMIT;
        end else begin
          state_nxt = iee_pkg::BK_OPND;
        end
      end
      iee_pkg::BK_OPND: begin
        state_nxt = (pend_r == iee_pkg::OP_NONE) ? iee_pkg::BK_AFTER : iee_pkg::BK_MDWAIT;
      end
      iee_pkg::BK_MDWAIT: begin
        if (md_rsp.done) state_nxt = iee_pkg::BK_AFTER;
      end
      iee_pkg::BK_AFTER: begin
        if (tok_r.kind == iee_pkg::TK_MUL || tok_r.kind == iee_pkg::TK_DIV) begin
          state_nxt = iee_pkg::BK_CHKLAST;
        end else begin
          state_nxt = iee_pkg::BK_TERM;
        end
      end
      iee_pkg::BK_TERM: begin
        if (tok_r.kind == iee_pkg::TK_ADD || tok_r.kind == iee_pkg::TK_SUB) begin
          state_nxt = iee_pkg::BK_CHKLAST;
        end else begin
          state_nxt = iee_pkg::BK_EMIT;
        end
      end
      iee_pkg::BK_EMIT: begin
        if (emit_ok) state_nxt = iee_pkg::BK_IDLE;
      end
      default: state_nxt = iee_pkg::BK_IDLE;
    endcase
  end

  // Outputs to queue and multiply/divide unit
  always_comb begin
    q_pop         = 1'b0;
    md_req.start  = 1'b0;
    md_req.is_div = (pend_r == iee_pkg::OP_DIV);
    unique case (state_r)
      iee_pkg::BK_IDLE: q_pop        = q_valid;
      iee_pkg::BK_OPND: md_req.start = (pend_r != iee_pkg::OP_NONE);
      default: begin
      end
    endcase
  end

  // Sequencer and expression state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iee_pkg::BK_IDLE;
      pend_r      <= iee_pkg::OP_NONE;
      sum_r       <= '0;
      term_r      <= '0;
      acc_r       <= '0;
      sub_r       <= 1'b0;
      err_r       <= iee_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Result valid: set on a result load, cleared when taken
      if (state_r == iee_pkg::BK_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        iee_pkg::BK_IDLE: begin
          if (q_valid) tok_r <= q_tok;
        end
        iee_pkg::BK_DECODE: begin
          if (err_r == iee_pkg::ST_OK && tok_r.kind == iee_pkg::TK_DIGIT) begin
            if (dig_ovf) begin
              err_r <= iee_pkg::ST_OVF;
            end else begin
              acc_r <= acc10[W-1:0];
            end
          end
        end
        iee_pkg::BK_CHKLAST: begin
          // from here on the token only drives the final fold
          tok_r.kind <= iee_pkg::TK_NONE;
        end
        iee_pkg::BK_OPND: begin
          if (pend_r == iee_pkg::OP_NONE) begin
            term_r <= acc_r;
            acc_r  <= '0;
          end
        end
        iee_pkg::BK_MDWAIT: begin
          if (md_rsp.done) begin
            term_r <= md_result;
            acc_r  <= '0;
            if (err_r == iee_pkg::ST_OK) err_r <= md_rsp.err;
          end
        end
        iee_pkg::BK_AFTER: begin
          if (tok_r.kind == iee_pkg::TK_MUL) pend_r <= iee_pkg::OP_MUL;
          if (tok_r.kind == iee_pkg::TK_DIV) pend_r <= iee_pkg::OP_DIV;
        end
        iee_pkg::BK_TERM: begin
          if (as_ovf) begin
            sum_r <= '0;
            if (err_r == iee_pkg::ST_OK) err_r <= iee_pkg::ST_OVF;
          end else begin
            sum_r <= $signed(sum_w[W-1:0]);
          end
          term_r <= '0;
          pend_r <= iee_pkg::OP_NONE;
          if (tok_r.kind == iee_pkg::TK_ADD || tok_r.kind == iee_pkg::TK_SUB) begin
            sub_r <= (tok_r.kind == iee_pkg::TK_SUB);
          end
        end
        iee_pkg::BK_EMIT: begin
          if (emit_ok) begin
            out_value_r  <= (err_r == iee_pkg::ST_OK) ? 32'(sum_r) : 32'd0;
            out_status_r <= err_r;
            sum_r        <= '0;
            term_r       <= '0;
            acc_r        <= '0;
            pend_r       <= iee_pkg::OP_NONE;
            sub_r        <= 1'b0;
            err_r        <= iee_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A delivered result leaves a clean expression state behind
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iee_pkg::BK_EMIT && emit_ok) |=>
      (out_tvalid && sum_r == '0 && err_r == iee_pkg::ST_OK && pend_r == iee_pkg::OP_NONE))
    else $error("result load did not clear expression state");

  // First error sticks until the result goes out
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != iee_pkg::ST_OK && state_r != iee_pkg::BK_EMIT) |=> (err_r == $past(err_r)))
    else $error("error code changed before result");

  // Operand accumulator never reaches the sign bit
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n) !acc_r[W-1])
    else $error("operand accumulator out of range");

  // The shared unit only starts with an operator pending
  a_md_start: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> (pend_r != iee_pkg::OP_NONE && err_r == iee_pkg::ST_OK))
    else $error("multiply/divide started without pending operator");

endmodule
`default_nettype wire

// File: rtl/core/infix_expression_evaluator_top.sv
`default_nettype none
// Channel   Direction  Payload
// in_*      slave      tdata[7:0] char_code, tlast last_char
// out_*     master     tdata[31:0] value, tdata[33:32] status, tdata[39:34] zero
//
// A digit passes the back-end decode and last-check states; other characters are dropped
// at the input unless marked last. '+'/'-' also closes the term and folds it into the sum;
// a last digit does the fold and the result load. With a multiply or divide pending, an
// operator first waits on the shift-add / restoring-divide unit, which works 1 bit/cycle.
// A 4-entry token queue and the result register let input flow while the back end
// computes or a result waits; synchronous active-low reset, no clearing pass.
module infix_expression_evaluator_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [7:0]   in_tdata,    // [7:0] char_code
  input  wire         in_tlast,    // last_char
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

  iee_pkg::tok_t            push_tok, head_tok;
  logic                     q_push, q_full, q_valid, q_pop;
  iee_pkg::md_req_t         md_req;
  iee_pkg::md_rsp_t         md_rsp;
  logic signed [VALUE_WIDTH-1:0] md_a, md_b, md_result;
  logic [31:0]              out_value;
  logic [1:0]               out_status;

  iee_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  iee_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_tok (head_tok)
  );

  iee_muldiv #(.W(VALUE_WIDTH)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .op_a   (md_a),
    .op_b   (md_b),
    .rsp    (md_rsp),
    .result (md_result)
  );

  iee_back #(.W(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_tok      (head_tok),
    .q_pop      (q_pop),
    .md_req     (md_req),
    .md_a       (md_a),
    .md_b       (md_b),
    .md_rsp     (md_rsp),
    .md_result  (md_result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  // Pack result fields
  assign out_tdata = {6'b0, out_status, out_value};

endmodule
`default_nettype wire
